@@ src/heading_pd_drive_regulator_unit_defines.svh @@
// Assertion macros for the heading PD drive regulator RTL, used by hpdr_err_stage.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef HEADING_PD_DRIVE_REGULATOR_UNIT_DEFINES_SVH
`define HEADING_PD_DRIVE_REGULATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPDR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HPDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/hpdr_pkg.sv @@
// Shared types and constants of the heading PD drive regulator.
// No dependencies; every RTL module imports this package.
package hpdr_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DRIVE = 2'd0,
        ST_BUMP  = 2'd1,
        ST_SONAR = 2'd2
    } t_status;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [2:0] CFG_DERIV_GAIN  = 3'd1;
    localparam logic [2:0] CFG_CORR_LIMIT  = 3'd2;
    localparam logic [2:0] CFG_FAST_SPEED  = 3'd3;
    localparam logic [2:0] CFG_SLOW_SPEED  = 3'd4;
    localparam logic [2:0] CFG_STOP_DIST   = 3'd5;
    localparam logic [2:0] CFG_WARN_DIST   = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [9:0] RST_PROP_GAIN  = 10'd77;
    localparam logic [9:0] RST_DERIV_GAIN = 10'd205;
    localparam logic [6:0] RST_CORR_LIMIT = 7'd15;
    localparam logic [7:0] RST_FAST_SPEED = 8'd100;
    localparam logic [7:0] RST_SLOW_SPEED = 8'd90;
    localparam logic [7:0] RST_STOP_DIST  = 8'd15;
    localparam logic [7:0] RST_WARN_DIST  = 8'd30;

    // Angle wrap constants in degrees.
    localparam logic signed [10:0] HALF_TURN = 11'sd180;
    localparam logic signed [10:0] FULL_TURN = 11'sd360;

    typedef struct packed {
        logic [9:0] prop_gain_q8;
        logic [9:0] deriv_gain_q8;
        logic [6:0] correction_limit;
        logic [7:0] fast_speed;
        logic [7:0] slow_speed;
        logic [7:0] stop_distance;
        logic [7:0] warn_distance;
    } t_cfg;

    // Beat handed from the error stage to the drive stage.
    typedef struct packed {
        t_status            status;
        logic signed [8:0]  err;
        logic signed [9:0]  derr;
        logic [7:0]         base;
    } t_mid;

endpackage

@@ src/heading_pd_drive_regulator_unit.sv @@
// Top level of the heading PD drive regulator: config registers, error stage
// and drive stage. Depends on hpdr_pkg, hpdr_cfg_regs, hpdr_err_stage, hpdr_drive_stage.
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_valid / o_stall          heading, three sonars, three bumpers
//  result    out        o_valid / i_stall          status, speed_left, speed_right
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A beat is accepted every cycle while o_stall is low; it moves through the input
// register, the error register and the result register in that order.
// The heading error update loops through the error stage's own state registers, so one
// beat per cycle is the sustained rate while the result side does not stall.
// Reset is synchronous and active low; it restores register defaults and drops the target.
// A stall on the result side fills the three registers before o_stall rises.
// The config port never stalls; the user must keep writes to an empty pipeline, unchecked.
module heading_pd_drive_regulator_unit import hpdr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [8:0]  i_heading,
    input  logic [7:0]  i_sonar_center,
    input  logic [7:0]  i_sonar_left,
    input  logic [7:0]  i_sonar_right,
    input  logic        i_bump_left,
    input  logic        i_bump_center,
    input  logic        i_bump_right,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_speed_left,
    output logic [7:0]  o_speed_right,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    t_cfg  w_cfg;
    t_mid  w_mid;
    logic  w_mid_valid;
    logic  w_mid_ready;
    logic  w_bumped;

    // Only the fact that some bumper is pressed matters downstream.
    assign w_bumped = i_bump_left | i_bump_center | i_bump_right;

    hpdr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    // Stop detection, target capture and the wrapped heading error.
    hpdr_err_stage u_err (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_heading      (i_heading),
        .i_sonar_center (i_sonar_center),
        .i_sonar_left   (i_sonar_left),
        .i_sonar_right  (i_sonar_right),
        .i_bumped       (w_bumped),
        .o_mid_valid    (w_mid_valid),
        .o_mid          (w_mid),
        .i_mid_ready    (w_mid_ready)
    );

    // PD multiply, clamp and wheel saturation into the result register.
    hpdr_drive_stage u_drive (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_mid_valid   (w_mid_valid),
        .i_mid         (w_mid),
        .o_mid_ready   (w_mid_ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_speed_left  (o_speed_left),
        .o_speed_right (o_speed_right)
    );

endmodule

@@ src/hpdr_cfg_regs.sv @@
// Configuration register file of the heading PD drive regulator.
// Depends on hpdr_pkg for register indexes, reset values and t_cfg.
module hpdr_cfg_regs import hpdr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    output logic        o_cfg_ready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:  n_cfg.prop_gain_q8     = i_cfg_data;
                CFG_DERIV_GAIN: n_cfg.deriv_gain_q8    = i_cfg_data;
                CFG_CORR_LIMIT: n_cfg.correction_limit = i_cfg_data[6:0];
                CFG_FAST_SPEED: n_cfg.fast_speed       = i_cfg_data[7:0];
                CFG_SLOW_SPEED: n_cfg.slow_speed       = i_cfg_data[7:0];
                CFG_STOP_DIST:  n_cfg.stop_distance    = i_cfg_data[7:0];
                CFG_WARN_DIST:  n_cfg.warn_distance    = i_cfg_data[7:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain_q8     <= RST_PROP_GAIN;
            r_cfg.deriv_gain_q8    <= RST_DERIV_GAIN;
            r_cfg.correction_limit <= RST_CORR_LIMIT;
            r_cfg.fast_speed       <= RST_FAST_SPEED;
            r_cfg.slow_speed       <= RST_SLOW_SPEED;
            r_cfg.stop_distance    <= RST_STOP_DIST;
            r_cfg.warn_distance    <= RST_WARN_DIST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ src/hpdr_err_stage.sv @@
// Input register and heading error stage: stop detection, target capture,
// wrapped error and its difference. Depends on hpdr_pkg and the defines header.
`include "heading_pd_drive_regulator_unit_defines.svh"

module hpdr_err_stage import hpdr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [8:0]  i_heading,
    input  logic [7:0]  i_sonar_center,
    input  logic [7:0]  i_sonar_left,
    input  logic [7:0]  i_sonar_right,
    input  logic        i_bumped,
    output logic        o_mid_valid,
    output t_mid        o_mid,
    input  logic        i_mid_ready
);

    // Input register.
    logic              r_in_valid;
    logic [8:0]        r_heading;
    logic [7:0]        r_sonar_c;
    logic [7:0]        r_sonar_l;
    logic [7:0]        r_sonar_r;
    logic              r_bumped;

    // Heading loop state.
    logic              r_target_valid;
    logic [8:0]        r_target_heading;
    logic signed [8:0] r_last_error;

    // Stage output register.
    logic              r_mid_valid;
    t_mid              r_mid;

    logic              w_accept;
    logic              w_advance;
    logic              w_mid_ready;
    logic              w_blocked;
    logic              w_slow;
    logic              w_stop;
    logic [8:0]        w_tgt;
    logic signed [8:0] w_lerr;
    logic signed [10:0] w_raw;
    logic signed [10:0] w_wrap;
    logic signed [10:0] w_err11;
    t_mid              n_mid;

    assign w_mid_ready = !r_mid_valid || i_mid_ready;
    assign w_advance   = r_in_valid && w_mid_ready;
    assign o_stall     = r_in_valid && !w_mid_ready;
    assign w_accept    = i_valid && !o_stall;

    assign w_blocked = (r_sonar_c <= i_cfg.stop_distance) ||
                       (r_sonar_l <= i_cfg.stop_distance) ||
                       (r_sonar_r <= i_cfg.stop_distance);
    assign w_slow    = (r_sonar_c < i_cfg.warn_distance) ||
                       (r_sonar_l < i_cfg.warn_distance) ||
                       (r_sonar_r < i_cfg.warn_distance);
    assign w_stop    = r_bumped || w_blocked;

    // The first driving beat after a stop captures its own heading.
    assign w_tgt  = r_target_valid ? r_target_heading : r_heading;
    assign w_lerr = r_target_valid ? r_last_error : 9'sd0;

    always_comb begin
        w_raw   = $signed({2'b00, w_tgt}) - $signed({2'b00, r_heading});
        w_wrap  = (w_raw > HALF_TURN) ? (w_raw - FULL_TURN) : w_raw;
        w_err11 = (w_wrap < -HALF_TURN) ? (w_wrap + FULL_TURN) : w_wrap;

        n_mid.err  = w_err11[8:0];
        n_mid.derr = {n_mid.err[8], n_mid.err} - {w_lerr[8], w_lerr};
        n_mid.base = w_slow ? i_cfg.slow_speed : i_cfg.fast_speed;
        if (r_bumped) begin
            n_mid.status = ST_BUMP;
        end else if (w_blocked) begin
            n_mid.status = ST_SONAR;
        end else begin
            n_mid.status = ST_DRIVE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_heading <= i_heading;
            r_sonar_c <= i_sonar_center;
            r_sonar_l <= i_sonar_left;
            r_sonar_r <= i_sonar_right;
            r_bumped  <= i_bumped;
        end
        if (w_advance) begin
            r_mid <= n_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_mid_valid      <= 1'b0;
            r_target_valid   <= 1'b0;
            r_target_heading <= '0;
            r_last_error     <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_mid_valid <= 1'b1;
            end else if (i_mid_ready) begin
                r_mid_valid <= 1'b0;
            end
            if (w_advance) begin
                if (w_stop) begin
                    r_target_valid   <= 1'b0;
                    r_target_heading <= '0;
                    r_last_error     <= '0;
                end else begin
                    r_target_valid   <= 1'b1;
                    r_target_heading <= w_tgt;
                    r_last_error     <= n_mid.err;
                end
            end
        end
    end

    assign o_mid_valid = r_mid_valid;
    assign o_mid       = r_mid;

    `HPDR_ASSERT_SAME(a_no_target_no_error, !r_target_valid, r_last_error == 9'sd0,
        "previous error is nonzero without a captured target")
    `HPDR_ASSERT_SAME(a_err_wrapped, r_mid_valid && (r_mid.status == ST_DRIVE),
        (r_mid.err >= -9'sd180) && (r_mid.err <= 9'sd180),
        "heading error left the wrapped range")
    `HPDR_ASSERT_NEXT(a_stop_drops_target, w_advance && w_stop, !r_target_valid,
        "a stop beat did not drop the captured target")

endmodule

@@ src/hpdr_drive_stage.sv @@
// PD correction, clamp and wheel speed saturation, ending in the result register.
// Depends on hpdr_pkg for t_cfg, t_mid and the status codes.
module hpdr_drive_stage import hpdr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_mid_valid,
    input  t_mid        i_mid,
    output logic        o_mid_ready,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_speed_left,
    output logic [7:0]  o_speed_right
);

    logic               r_valid;
    logic [1:0]         r_status;
    logic [7:0]         r_speed_l;
    logic [7:0]         r_speed_r;

    logic               w_load;
    logic signed [21:0] w_p_term;
    logic signed [21:0] w_d_term;
    logic signed [21:0] w_corr;
    logic signed [21:0] w_limit;
    logic signed [21:0] w_clamped;
    logic signed [21:0] w_base;
    logic signed [21:0] w_sum_l;
    logic signed [21:0] w_sum_r;
    logic [7:0]         n_speed_l;
    logic [7:0]         n_speed_r;

    // Truncation toward zero of a negative sum never gives a positive speed,
    // so any negative sum reads as zero.
    function automatic logic [7:0] wheel_sat(input logic signed [21:0] sum_q8);
        logic [7:0] res;
        if (sum_q8[21]) begin
            res = 8'd0;
        end else if (|sum_q8[20:16]) begin
            res = 8'hFF;
        end else begin
            res = sum_q8[15:8];
        end
        return res;
    endfunction

    assign o_mid_ready = !r_valid || !i_stall;
    assign w_load      = i_mid_valid && o_mid_ready;

    always_comb begin
        // Both factors are widened to the full term width before the multiply.
        w_p_term = $signed({12'd0, i_cfg.prop_gain_q8}) *
                   $signed({{13{i_mid.err[8]}}, i_mid.err});
        w_d_term = $signed({12'd0, i_cfg.deriv_gain_q8}) *
                   $signed({{12{i_mid.derr[9]}}, i_mid.derr});
        w_corr   = w_p_term + w_d_term;
        w_limit  = $signed({7'd0, i_cfg.correction_limit, 8'd0});
        if (w_corr > w_limit) begin
            w_clamped = w_limit;
        end else if (w_corr < -w_limit) begin
            w_clamped = -w_limit;
        end else begin
            w_clamped = w_corr;
        end
        w_base  = $signed({6'd0, i_mid.base, 8'd0});
        w_sum_l = w_base + w_clamped;
        w_sum_r = w_base - w_clamped;
        if (i_mid.status == ST_DRIVE) begin
            n_speed_l = wheel_sat(w_sum_l);
            n_speed_r = wheel_sat(w_sum_r);
        end else begin
            n_speed_l = 8'd0;
            n_speed_r = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status  <= i_mid.status;
            r_speed_l <= n_speed_l;
            r_speed_r <= n_speed_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_speed_left  = r_speed_l;
    assign o_speed_right = r_speed_r;

endmodule

@@ tb/sv/heading_pd_drive_regulator_unit_test.sv @@
// Self-checking testbench for heading_pd_drive_regulator_unit: directed and random sensor beats,
// checked against an in-bench model of the heading PD controller, over several settings.
// Depends on hpdr_pkg and the RTL of heading_pd_drive_regulator_unit.
module heading_pd_drive_regulator_unit_test;
    import hpdr_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 11;
    // Even with every beat meeting the longest sender gap and the longest result hold-off,
    // the slowest correct run stays far inside this bound, which leaves a wide margin.
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int DRAIN_LIMIT    = 2000;
    // The pipeline is three registers deep, so the tail of TAIL_CYCLES at the end is plenty
    // to catch a stray result beat.
    localparam int TAIL_CYCLES    = 10;

    // The config port decodes three index bits, but only seven registers exist; a write to
    // the spare index must leave every register alone.
    localparam logic [2:0] CFG_SPARE_INDEX = 3'd7;

    typedef struct packed {
        logic [8:0] heading;
        logic [7:0] sonar_center, sonar_left, sonar_right;
        logic       bump_left, bump_center, bump_right;
    } t_sensor_beat;

    typedef struct packed {
        t_status    status;
        logic [7:0] speed_left, speed_right;
    } t_wheel_cmd;

    typedef struct packed {
        t_sensor_beat beat;
        logic         typed;
        t_wheel_cmd   want;
    } t_directed_row;

    localparam t_wheel_cmd NO_CMD = '{ST_DRIVE, 8'd0, 8'd0};

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [8:0] i_heading;
    logic [7:0] i_sonar_center, i_sonar_left, i_sonar_right;
    logic       i_bump_left, i_bump_center, i_bump_right;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_status;
    logic [7:0] o_speed_left, o_speed_right;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [9:0] i_cfg_data;

    // A directed beat can carry a hand-written expectation. It travels with the payload so
    // that the monitor picks it up on exactly the edge at which the beat is accepted.
    logic       beat_typed;
    t_wheel_cmd beat_want;

    // Model of the block: its own copy of the registers and of the steering state.
    t_cfg       cfg_model;
    logic       target_held;
    logic [8:0] held_heading;
    int         prev_err;

    t_wheel_cmd wheel_cmds_due[$];
    int         mismatch_count = 0;

    // Directed beats, walked in order with the reset settings (stop at 15, warn at 30,
    // fast 100, slow 90). Rows with a typed result can be read off at a glance; the rest go
    // through the model.
    t_directed_row directed_rows [22] = '{
        // Each bumper alone, then all three with every sonar at zero: the bumper wins.
        '{'{9'd0,   8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0}, 1'b1, '{ST_BUMP, 8'd0, 8'd0}},
        '{'{9'd359, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b0}, 1'b1, '{ST_BUMP, 8'd0, 8'd0}},
        '{'{9'd511, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b1}, 1'b1, '{ST_BUMP, 8'd0, 8'd0}},
        '{'{9'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 1'b1}, 1'b1, '{ST_BUMP, 8'd0, 8'd0}},
        // Each sonar exactly at or below the stop distance.
        '{'{9'd0,   8'd15,  8'd255, 8'd255, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_SONAR, 8'd0, 8'd0}},
        '{'{9'd0,   8'd255, 8'd0,   8'd255, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_SONAR, 8'd0, 8'd0}},
        '{'{9'd0,   8'd255, 8'd255, 8'd15,  1'b0, 1'b0, 1'b0}, 1'b1, '{ST_SONAR, 8'd0, 8'd0}},
        // Just clear of the stop distance but inside the warn zone: capture, slow base.
        '{'{9'd359, 8'd16,  8'd16,  8'd16,  1'b0, 1'b0, 1'b0}, 1'b1, '{ST_DRIVE, 8'd90, 8'd90}},
        // Small error across north, a clamped error, slow and fast bases mixed.
        '{'{9'd0,   8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0}, 1'b0, NO_CMD},
        '{'{9'd179, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0}, 1'b0, NO_CMD},
        '{'{9'd90,  8'd29,  8'd255, 8'd255, 1'b0, 1'b0, 1'b0}, 1'b0, NO_CMD},
        '{'{9'd200, 8'd255, 8'd255, 8'd16,  1'b0, 1'b0, 1'b0}, 1'b0, NO_CMD},
        // Drop the target, then capture north with every sonar exactly at the warn distance.
        '{'{9'd100, 8'd15,  8'd15,  8'd15,  1'b0, 1'b0, 1'b0}, 1'b1, '{ST_SONAR, 8'd0, 8'd0}},
        '{'{9'd0,   8'd30,  8'd30,  8'd30,  1'b0, 1'b0, 1'b0}, 1'b1, '{ST_DRIVE, 8'd100, 8'd100}},
        // Error of exactly a half turn, one past it, and headings beyond a full turn.
        '{'{9'd180, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0}, 1'b0, NO_CMD},
        '{'{9'd181, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0}, 1'b0, NO_CMD},
        '{'{9'd511, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0}, 1'b0, NO_CMD},
        '{'{9'd360, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0}, 1'b0, NO_CMD},
        // A target captured beyond a full turn, then steered against from north.
        '{'{9'd0,   8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0}, 1'b1, '{ST_BUMP, 8'd0, 8'd0}},
        '{'{9'd511, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_DRIVE, 8'd100, 8'd100}},
        '{'{9'd0,   8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0}, 1'b0, NO_CMD},
        '{'{9'd300, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0}, 1'b0, NO_CMD}
    };

    heading_pd_drive_regulator_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_heading      (i_heading),
        .i_sonar_center (i_sonar_center),
        .i_sonar_left   (i_sonar_left),
        .i_sonar_right  (i_sonar_right),
        .i_bump_left    (i_bump_left),
        .i_bump_center  (i_bump_center),
        .i_bump_right   (i_bump_right),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_speed_left   (o_speed_left),
        .o_speed_right  (o_speed_right),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Whole wheel speed from a Q8 sum: truncate toward zero, then saturate to a byte.
    function automatic logic [7:0] wheel_speed(int sum_q8);
        int whole;
        whole = sum_q8 / 256;
        if (whole < 0) return 8'd0;
        if (whole > 255) return 8'd255;
        return 8'(whole);
    endfunction

    // Steps the model by one accepted sensor beat and returns the wheel command it causes.
    function automatic t_wheel_cmd predict_wheel_cmd(t_sensor_beat b);
        t_wheel_cmd cmd;
        logic       bumped, blocked, near;
        int         head, err, derr, corr, limit_q8, base_q8, p_gain, d_gain;
        cmd     = NO_CMD;
        bumped  = b.bump_left | b.bump_center | b.bump_right;
        blocked = b.sonar_center <= cfg_model.stop_distance ||
                  b.sonar_left   <= cfg_model.stop_distance ||
                  b.sonar_right  <= cfg_model.stop_distance;
        if (bumped || blocked) begin
            target_held  = 1'b0;
            held_heading = '0;
            prev_err     = 0;
            cmd.status   = bumped ? ST_BUMP : ST_SONAR;
            return cmd;
        end
        if (!target_held) begin
            target_held  = 1'b1;
            held_heading = b.heading;
            prev_err     = 0;
        end
        // Out-of-range headings are used as they come; a single wrap step is enough.
        head = int'(b.heading);
        err  = int'(held_heading);
        err  = err - head;
        if (err > HALF_TURN) err = err - FULL_TURN;
        if (err < -HALF_TURN) err = err + FULL_TURN;
        derr     = err - prev_err;
        prev_err = err;

        p_gain   = int'(cfg_model.prop_gain_q8);
        d_gain   = int'(cfg_model.deriv_gain_q8);
        corr     = p_gain * err + d_gain * derr;
        limit_q8 = int'(cfg_model.correction_limit);
        limit_q8 = limit_q8 * 256;
        if (corr > limit_q8) corr = limit_q8;
        if (corr < -limit_q8) corr = -limit_q8;

        near = b.sonar_center < cfg_model.warn_distance ||
               b.sonar_left   < cfg_model.warn_distance ||
               b.sonar_right  < cfg_model.warn_distance;
        base_q8 = near ? int'(cfg_model.slow_speed) : int'(cfg_model.fast_speed);
        base_q8 = base_q8 * 256;

        cmd.status      = ST_DRIVE;
        cmd.speed_left  = wheel_speed(base_q8 + corr);
        cmd.speed_right = wheel_speed(base_q8 - corr);
        return cmd;
    endfunction

    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        end
    endtask

    // Monitor. It samples on the rising edge, so every handshake signal is seen with its
    // value from before the edge, the same value the block itself acts on. Config writes,
    // accepted sensor beats and accepted result beats all go through this one process.
    always @(posedge i_clk) begin : track_beats
        t_sensor_beat seen;
        t_wheel_cmd   model_cmd, due;
        if (!i_rst_n) begin
            cfg_model.prop_gain_q8     = RST_PROP_GAIN;
            cfg_model.deriv_gain_q8    = RST_DERIV_GAIN;
            cfg_model.correction_limit = RST_CORR_LIMIT;
            cfg_model.fast_speed       = RST_FAST_SPEED;
            cfg_model.slow_speed       = RST_SLOW_SPEED;
            cfg_model.stop_distance    = RST_STOP_DIST;
            cfg_model.warn_distance    = RST_WARN_DIST;
            target_held  = 1'b0;
            held_heading = '0;
            prev_err     = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                case (i_cfg_index)
                    CFG_PROP_GAIN:  cfg_model.prop_gain_q8     = i_cfg_data;
                    CFG_DERIV_GAIN: cfg_model.deriv_gain_q8    = i_cfg_data;
                    CFG_CORR_LIMIT: cfg_model.correction_limit = i_cfg_data[6:0];
                    CFG_FAST_SPEED: cfg_model.fast_speed       = i_cfg_data[7:0];
                    CFG_SLOW_SPEED: cfg_model.slow_speed       = i_cfg_data[7:0];
                    CFG_STOP_DIST:  cfg_model.stop_distance    = i_cfg_data[7:0];
                    CFG_WARN_DIST:  cfg_model.warn_distance    = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // The expectation is queued before any result of this edge is checked, so the
            // order holds whatever the latency of the block is.
            if (i_valid && o_stall === 1'b0) begin
                seen = {i_heading, i_sonar_center, i_sonar_left, i_sonar_right,
                        i_bump_left, i_bump_center, i_bump_right};
                model_cmd = predict_wheel_cmd(seen);
                wheel_cmds_due.push_back(beat_typed ? beat_want : model_cmd);
            end
            if (o_valid === 1'b1 && !i_stall) begin
                if (wheel_cmds_due.size() == 0) begin
                    mismatch_count++;
                    $error("result beat with nothing expected: status %0d, speeds %0d/%0d",
                           o_status, o_speed_left, o_speed_right);
                end else begin
                    due = wheel_cmds_due.pop_front();
                    check_field("status", 8'(due.status), 8'(o_status));
                    check_field("speed_left", due.speed_left, o_speed_left);
                    check_field("speed_right", due.speed_right, o_speed_right);
                end
            end
        end
    end

    // Sender gaps: mostly none, some short, a few long.
    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) return 0;
        if (pick < 88) return $urandom_range(3, 1);
        if (pick < 97) return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    task automatic idle_for(int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Puts one beat on the input channel and holds it until the block takes it. Valid stays
    // high on return, so a following beat can go out on the very next edge.
    task automatic offer_beat(t_sensor_beat b, logic typed, t_wheel_cmd want);
        i_valid        <= 1'b1;
        i_heading      <= b.heading;
        i_sonar_center <= b.sonar_center;
        i_sonar_left   <= b.sonar_left;
        i_sonar_right  <= b.sonar_right;
        i_bump_left    <= b.bump_left;
        i_bump_center  <= b.bump_center;
        i_bump_right   <= b.bump_right;
        beat_typed     <= typed;
        beat_want      <= want;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    // Stops sending and waits until every queued result has come back. The first edge lets
    // the monitor queue a beat taken on the edge this task was called at.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (wheel_cmds_due.size() != 0);
    endtask

    task automatic write_reg(logic [2:0] index, logic [9:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
    endtask

    // Loads a full setting once the pipeline is empty. Data wider than a register is passed
    // through on purpose, since the block must drop the upper bits.
    task automatic load_setting(logic [9:0] p_gain, logic [9:0] d_gain, logic [9:0] limit,
                                logic [9:0] fast, logic [9:0] slow, logic [9:0] stop_at,
                                logic [9:0] warn_at);
        wait_drained();
        write_reg(CFG_PROP_GAIN, p_gain);
        write_reg(CFG_DERIV_GAIN, d_gain);
        write_reg(CFG_CORR_LIMIT, limit);
        write_reg(CFG_FAST_SPEED, fast);
        write_reg(CFG_SLOW_SPEED, slow);
        write_reg(CFG_STOP_DIST, stop_at);
        write_reg(CFG_WARN_DIST, warn_at);
        write_reg(CFG_SPARE_INDEX, 10'($urandom_range(1023)));
        i_cfg_valid <= 1'b0;
    endtask

    // A sonar reading that keeps the path open, leaning now and then toward the warn
    // distance so both base speeds and the warn boundary get exercised.
    function automatic logic [7:0] clear_sonar();
        int lo, hi;
        if (cfg_model.stop_distance == 8'd255) return 8'($urandom_range(255));
        lo = int'(cfg_model.stop_distance) + 1;
        if ($urandom_range(3) == 0) begin
            hi = int'(cfg_model.warn_distance) + 2;
            if (hi > 255) hi = 255;
            if (hi < lo) hi = lo;
            return 8'($urandom_range(hi, lo));
        end
        return 8'($urandom_range(255, lo));
    endfunction

    // A heading close to the run's aim, with the odd wild one for large errors and wraps.
    function automatic logic [8:0] near_heading(int aim);
        int h;
        if ($urandom_range(7) == 0) return 9'($urandom_range(511));
        h = aim + int'($urandom_range(40)) - 20;
        if (aim < 360) h = (h + 360) % 360;
        else if (h > 511) h = 511;
        return 9'(h);
    endfunction

    function automatic t_sensor_beat drive_beat(int aim);
        t_sensor_beat b;
        b.heading      = near_heading(aim);
        b.sonar_center = clear_sonar();
        b.sonar_left   = clear_sonar();
        b.sonar_right  = clear_sonar();
        b.bump_left    = 1'b0;
        b.bump_center  = 1'b0;
        b.bump_right   = 1'b0;
        return b;
    endfunction

    function automatic t_sensor_beat noise_beat();
        t_sensor_beat b;
        b.heading      = 9'($urandom_range(511));
        b.sonar_center = 8'($urandom_range(255));
        b.sonar_left   = 8'($urandom_range(255));
        b.sonar_right  = 8'($urandom_range(255));
        b.bump_left    = 1'($urandom_range(1));
        b.bump_center  = 1'($urandom_range(1));
        b.bump_right   = 1'($urandom_range(1));
        return b;
    endfunction

    // Ends a run: one bumper pressed, or one sonar at or below the stop distance.
    function automatic t_sensor_beat stop_beat(int aim);
        t_sensor_beat b;
        logic [7:0]   close_in;
        b        = drive_beat(aim);
        close_in = 8'($urandom_range(cfg_model.stop_distance));
        case ($urandom_range(5))
            0: b.bump_left    = 1'b1;
            1: b.bump_center  = 1'b1;
            2: b.bump_right   = 1'b1;
            3: b.sonar_center = close_in;
            4: b.sonar_left   = close_in;
            default: b.sonar_right = close_in;
        endcase
        return b;
    endfunction

    // Random traffic as runs: a target is captured, held for a stretch of driving beats with
    // random content, then dropped by a bumper or a close sonar. Some runs go out with no gaps
    // at all, and a few beats are pure noise.
    task automatic run_phase(int n_beats);
        int           sent, run_len, aim, k;
        logic         eager;
        t_sensor_beat b;
        sent = 0;
        while (sent < n_beats) begin
            run_len = $urandom_range(25, 3);
            aim     = ($urandom_range(9) == 0) ? $urandom_range(511, 360) : $urandom_range(359);
            eager   = ($urandom_range(3) == 0);
            for (k = 0; k <= run_len; k++) begin
                if (k == run_len) b = stop_beat(aim);
                else if ($urandom_range(19) == 0) b = noise_beat();
                else b = drive_beat(aim);
                if (!eager) idle_for(sender_gap());
                offer_beat(b, 1'b0, NO_CMD);
            end
            sent += run_len + 1;
            if ($urandom_range(30) == 0) wait_drained();
        end
    endtask

    // Stimulus: reset, the directed table, then random runs over a series of settings.
    initial begin : sensor_feed
        int r, p, n;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_heading      <= '0;
        i_sonar_center <= '0;
        i_sonar_left   <= '0;
        i_sonar_right  <= '0;
        i_bump_left    <= 1'b0;
        i_bump_center  <= 1'b0;
        i_bump_right   <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        beat_typed     <= 1'b0;
        beat_want      <= NO_CMD;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < $size(directed_rows); r++) begin
            idle_for(sender_gap());
            offer_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want);
        end
        run_phase(230);

        // Largest gains and clamp, fast at full scale and slow at zero: both saturations.
        load_setting(10'd1023, 10'd1023, 10'd127, 10'd255, 10'd0, 10'd0, 10'd255);
        run_phase(200);
        // Zero gains and clamp, never slow, and a sonar stops only at a reading of zero.
        load_setting(10'd0, 10'd0, 10'd0, 10'd0, 10'd255, 10'd0, 10'd0);
        run_phase(80);
        // Stop distance at full scale: every beat is blocked.
        load_setting(10'd77, 10'd205, 10'd15, 10'd100, 10'd90, 10'd255, 10'd255);
        run_phase(40);
        for (p = 0; p < 5; p++) begin
            load_setting(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                         10'($urandom_range(1023)), 10'($urandom_range(1023)),
                         10'($urandom_range(1023)),
                         10'(($urandom_range(3) << 8) | $urandom_range(60)),
                         10'($urandom_range(1023)));
            run_phase(180);
        end

        i_valid <= 1'b0;
        n = 0;
        do begin
            @(posedge i_clk);
            n++;
        end while (wheel_cmds_due.size() != 0 && n < DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (wheel_cmds_due.size() != 0) begin
            mismatch_count++;
            $error("%0d result beats never arrived", wheel_cmds_due.size());
        end
        if (mismatch_count == 0) begin
            $display("heading_pd_drive_regulator_unit verification clean");
        end else begin
            $display("heading_pd_drive_regulator_unit verification failed");
        end
        $finish;
    end

    // Result side. It stalls in random bursts, mostly short, with long open stretches too.
    // Early on, and now and then later, it holds off for a long stretch while the sender keeps
    // offering, so the block fills up and has to stall its input.
    initial begin : result_taker
        int pick, hold, open_len, round;
        i_stall <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        round = 0;
        forever begin
            pick = $urandom_range(99);
            if (round == 4 || pick < 3) begin
                hold     = $urandom_range(80, 40);
                open_len = $urandom_range(4, 1);
            end else if (pick < 10) begin
                hold     = 0;
                open_len = $urandom_range(100, 40);
            end else begin
                hold     = $urandom_range(3);
                open_len = $urandom_range(8, 1);
            end
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat (open_len) @(posedge i_clk);
            round++;
        end
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("heading_pd_drive_regulator_unit verification failed");
        $finish;
    end

endmodule
